>>> rtl/core/rfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rfd_pkg;
  localparam logic [2:0] KIND_UINT   = 3'd0;
  localparam logic [2:0] KIND_SINT   = 3'd1;
  localparam logic [2:0] KIND_BOOL   = 3'd2;
  localparam logic [2:0] KIND_SINGLE = 3'd3;
  localparam logic [2:0] KIND_DOUBLE = 3'd4;

  typedef struct packed {
    logic [63:0] raw_window;
    logic [3:0]  byte_count;
    logic [5:0]  bit_start;
    logic [6:0]  bit_length;
    logic [2:0]  kind;
    logic        as_real;
    logic [15:0] byte_offset;
    logic [15:0] record_length;
  } rfd_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic        is_real;
    logic        fits;
  } rfd_out_t;

  // stage 1 -> stage 2 payload: loaded integer and control
  typedef struct packed {
    logic [63:0] v;
    logic [6:0]  blen;
    logic [5:0]  bstart;
    logic [6:0]  nbits;
    logic        sgn;
    logic        conv;
    logic [2:0]  kind;
    logic        fits;
  } rfd_s1_t;

  // stage 2 -> stage 3 payload: integer result ready for conversion
  typedef struct packed {
    logic [63:0] v;
    logic        conv;
    logic        is_real;
    logic        fits;
  } rfd_s2_t;
endpackage
`default_nettype wire

>>> rtl/core/rfd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rfd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/record_field_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Record field decoder: one field request in, one result request out. The
// core is a four-stage pipeline (byte load and overrun check, bit-field cut
// and single widening, magnitude normalize, round and pack) and takes one
// request per cycle while the output is not stalled. A stall freezes only
// the stages that are full behind it. cfg_wr_en writes big_endian
// (reset 1); write it only while the core is empty.
module record_field_decoder_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_wr_data,
  rfd_stream_if.sink          in_ch,
  rfd_stream_if.source        out_ch
);
  import rfd_pkg::*;
  logic      big_endian_r;
  logic [3:0] vld_r;
  logic [3:0] en;
  rfd_s1_t   s1_r;
  rfd_s2_t   s2_r;
  rfd_out_t  o_r;

  // stage k loads when it is empty or its content moves on
  always_comb begin
    en[3] = !vld_r[3] || out_ch.ready;
    en[2] = !vld_r[2] || en[3];
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end
  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld_r[3];
  assign out_ch.data  = o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b1;
      vld_r <= '0;
    end else begin
      if (cfg_wr_en) big_endian_r <= cfg_wr_data;
      if (en[0]) vld_r[0] <= in_ch.valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
    end
  end

  rfd_load u_load (
    .clk(clk), .en(en[0]), .big_endian(big_endian_r),
    .din(in_ch.data), .dout_r(s1_r)
  );
  rfd_extract u_extract (.clk(clk), .en(en[1]), .din(s1_r), .dout_r(s2_r));
  rfd_to_real u_to_real (
    .clk(clk), .en3(en[2]), .en4(en[3]), .din(s2_r), .dout_r(o_r)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.fits |->
      out_ch.data.value == 64'd0 && !out_ch.data.is_real)
    else $error("overrun result not zero");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ch.ready)
    else $error("empty front stage not ready");
endmodule
`default_nettype wire

>>> rtl/core/rfd_load.sv
`timescale 1ns / 1ps
`default_nettype none
// Stage 1: overrun check and byte load.
module rfd_load (
  input  wire                 clk,
  input  wire                 en,
  input  wire                 big_endian,
  input  rfd_pkg::rfd_in_t    din,
  output rfd_pkg::rfd_s1_t    dout_r
);
  import rfd_pkg::*;
  logic [3:0]  n;
  logic [3:0]  size;
  logic [16:0] endpos;
  logic [63:0] v;
  logic [63:0] wsel;
  rfd_s1_t     nxt;

  always_comb begin
    size = (din.kind == KIND_SINGLE) ? 4'd4 :
           (din.kind == KIND_DOUBLE) ? 4'd8 : din.byte_count;
    endpos = {1'b0, din.byte_offset} + {13'd0, size};
    n = (din.kind == KIND_SINGLE) ? 4'd4 :
        (din.kind == KIND_DOUBLE) ? 4'd8 :
        (din.byte_count > 4'd8) ? 4'd8 : din.byte_count;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      wsel[8*i +: 8] = (4'(i) < n) ? din.raw_window[8*i +: 8] : 8'd0;
    end
    if (big_endian) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) begin
          if ((4'(i) + 4'(j) + 4'd1) == n) v[8*j +: 8] = wsel[8*i +: 8];
        end
      end
    end else begin
      v = wsel;
    end
    if (din.kind == KIND_BOOL) v = {63'd0, din.raw_window[7:0] != 8'd0};
    nxt.v      = v;
    nxt.blen   = din.bit_length;
    nxt.bstart = din.bit_start;
    nxt.nbits  = {n, 3'd0};
    nxt.sgn    = (din.kind == KIND_SINT);
    nxt.conv   = din.as_real;
    nxt.kind   = din.kind;
    nxt.fits   = (endpos <= {1'b0, din.record_length});
  end

  always_ff @(posedge clk) begin
    if (en) dout_r <= nxt;
  end
endmodule
`default_nettype wire

>>> rtl/core/rfd_extract.sv
`timescale 1ns / 1ps
`default_nettype none
// Stage 2: bit-field cut, sign extension, single widening.
module rfd_extract (
  input  wire                 clk,
  input  wire                 en,
  input  rfd_pkg::rfd_s1_t    din,
  output rfd_pkg::rfd_s2_t    dout_r
);
  import rfd_pkg::*;
  logic [63:0] v, mask, m;
  logic [6:0]  sb;
  logic [63:0] dv;
  logic [31:0] s;
  logic [22:0] man, mn;
  logic [4:0]  lz;
  rfd_s2_t     nxt;

  always_comb begin
    v = din.v;
    sb = 7'd0;
    if (din.blen != 7'd0) begin
      mask = (din.blen >= 7'd64) ? '1 : ((64'd1 << din.blen[5:0]) - 64'd1);
      v = (v >> din.bstart) & mask;
      sb = (din.blen >= 7'd64) ? 7'd0 : din.blen;
    end else begin
      mask = '1;
      sb = (din.nbits >= 7'd64) ? 7'd0 : din.nbits;
    end
    if (din.sgn && sb != 7'd0) begin
      m = 64'd1 << (sb[5:0] - 6'd1);
      v = ((v & ((m << 1) - 64'd1)) ^ m) - m;
    end else begin
      m = '0;
    end
    // single to double
    s = din.v[31:0];
    man = s[22:0];
    lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (man[i]) lz = 5'(22 - i);
    end
    mn = man << (lz + 5'd1);
    if (s[30:23] == 8'hFF) begin
      dv = (man == 23'd0) ? {s[31], 63'h7FF0000000000000} :
           {s[31], 63'h7FF8000000000000} | ({41'd0, man} << 29);
    end else if (s[30:23] == 8'd0) begin
      dv = (man == 23'd0) ? {s[31], 63'd0} :
           {s[31], 11'(11'd896 - {6'd0, lz}), mn, 29'd0};
    end else begin
      dv = {s[31], 11'({3'd0, s[30:23]} + 11'd896), man, 29'd0};
    end
    nxt.fits = din.fits;
    if (!din.fits) begin
      nxt.v = '0; nxt.conv = 1'b0; nxt.is_real = 1'b0;
    end else if (din.kind == KIND_SINGLE) begin
      nxt.v = dv; nxt.conv = 1'b0; nxt.is_real = 1'b1;
    end else if (din.kind == KIND_DOUBLE) begin
      nxt.v = din.v; nxt.conv = 1'b0; nxt.is_real = 1'b1;
    end else if (din.kind == KIND_BOOL) begin
      nxt.v = din.v; nxt.conv = 1'b0; nxt.is_real = 1'b0;
    end else begin
      nxt.v = v; nxt.conv = din.conv; nxt.is_real = din.conv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout_r <= nxt;
  end
endmodule
`default_nettype wire

>>> rtl/core/rfd_to_real.sv
`timescale 1ns / 1ps
`default_nettype none
// Stages 3 and 4: integer to double. Magnitude and normalize, then round.
module rfd_to_real (
  input  wire                 clk,
  input  wire                 en3,
  input  wire                 en4,
  input  rfd_pkg::rfd_s2_t    din,
  output rfd_pkg::rfd_out_t   dout_r
);
  import rfd_pkg::*;
  typedef struct packed {
    logic [63:0] norm;
    logic [5:0]  msb;
    logic        neg;
    logic        zero;
    logic        conv;
    logic [63:0] raw;
    logic        is_real;
    logic        fits;
  } s3_t;
  s3_t         s3_r, s3_nxt;
  logic [63:0] mag;
  logic [5:0]  msb;
  logic        g, st, lsb, up;
  logic [53:0] rm;
  logic [10:0] ex;
  rfd_out_t    o_nxt;

  always_comb begin
    mag = din.v[63] ? (~din.v + 64'd1) : din.v;
    msb = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) msb = 6'(i);
    end
    s3_nxt.norm    = mag << (6'd63 - msb);
    s3_nxt.msb     = msb;
    s3_nxt.neg     = din.v[63];
    s3_nxt.zero    = (din.v == 64'd0);
    s3_nxt.conv    = din.conv;
    s3_nxt.raw     = din.v;
    s3_nxt.is_real = din.is_real;
    s3_nxt.fits    = din.fits;
  end

  always_ff @(posedge clk) begin
    if (en3) s3_r <= s3_nxt;
  end

  always_comb begin
    lsb = s3_r.norm[11];
    g   = s3_r.norm[10];
    st  = |s3_r.norm[9:0];
    up  = g & (st | lsb);
    rm  = {1'b0, s3_r.norm[63:11]} + {53'd0, up};
    ex  = 11'd1023 + {5'd0, s3_r.msb} + {10'd0, rm[53]};
    o_nxt.is_real = s3_r.is_real;
    o_nxt.fits    = s3_r.fits;
    if (!s3_r.conv) o_nxt.value = s3_r.raw;
    else if (s3_r.zero) o_nxt.value = '0;
    else o_nxt.value = {s3_r.neg, ex, rm[53] ? rm[52:1] : rm[51:0]};
  end

  always_ff @(posedge clk) begin
    if (en4) dout_r <= o_nxt;
  end
endmodule
`default_nettype wire

>>> dv/tb_record_field_decoder_core.sv
`timescale 1ns / 1ps
module tb_record_field_decoder_core;
  import rfd_pkg::*;

  // Overrun check needs the loaded field size; single and double are fixed width.
  localparam int PIPE_DRAIN = 12;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  rfd_stream_if #(.payload_t(rfd_in_t))  in_ch ();
  rfd_stream_if #(.payload_t(rfd_out_t)) out_ch ();

  record_field_decoder_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  // Shadow copy of the byte-order register.
  logic     big_endian_q;
  rfd_out_t decoded_q[$];
  int       errors;
  int       idle_cycles;
  int       send_gap_pct;
  int       sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gather n bytes of the window in the configured byte order.
  function automatic logic [63:0] gather_bytes(logic [63:0] win, int n, logic be);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < n && i < 8; i++) begin
      if (be) acc = (acc << 8) | {56'd0, win[8*i +: 8]};
      else    acc[8*i +: 8] = win[8*i +: 8];
    end
    return acc;
  endfunction

  function automatic logic [63:0] sign_fill(logic [63:0] v, int bits);
    logic [63:0] m;
    if (bits == 0 || bits >= 64) return v;
    m = 64'd1 << (bits - 1);
    v = v & ((m << 1) - 64'd1);
    return (v ^ m) - m;
  endfunction

  // Exact single to double widening, subnormals normalized, NaN quieted.
  function automatic logic [63:0] single_to_double(logic [31:0] s);
    logic [63:0] sgn;
    logic [7:0]  ex;
    logic [63:0] fr;
    int          shift;
    sgn = {s[31], 63'd0};
    ex  = s[30:23];
    fr  = {41'd0, s[22:0]};
    shift = 0;
    if (ex == 8'hFF) begin
      if (fr == 0) return sgn | 64'h7FF0_0000_0000_0000;
      return sgn | 64'h7FF8_0000_0000_0000 | (fr << 29);
    end
    if (ex == 0) begin
      if (fr == 0) return sgn;
      while (fr[23] == 1'b0) begin
        fr = fr << 1;
        shift++;
      end
      return sgn | (64'(897 - shift) << 52) | ((fr & 64'h7FFFFF) << 29);
    end
    return sgn | (64'(ex + 896) << 52) | (fr << 29);
  endfunction

  // Two's complement integer to double, round to nearest even.
  function automatic logic [63:0] int_to_double(logic [63:0] v);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    int          msb;
    int          sh;
    int          ex;
    neg = v[63];
    mag = neg ? (~v + 64'd1) : v;
    if (mag == 0) return 64'd0;
    msb = 63;
    while (mag[msb] == 1'b0) msb--;
    ex = msb;
    if (msb <= 52) begin
      mant = mag << (52 - msb);
    end else begin
      sh   = msb - 52;
      mant = mag >> sh;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
      if (mant[53]) begin
        mant = mant >> 1;
        ex++;
      end
    end
    return {neg, 11'(ex + 1023), mant[51:0]};
  endfunction

  function automatic rfd_out_t decode_field(rfd_in_t f, logic be);
    rfd_out_t    r;
    int          size;
    int          nbytes;
    logic [63:0] v;
    logic [63:0] mask;
    r = '0;
    size = (f.kind == KIND_SINGLE) ? 4 : (f.kind == KIND_DOUBLE) ? 8 : int'(f.byte_count);
    if (int'(f.byte_offset) + size > int'(f.record_length)) return r;
    r.fits = 1'b1;
    case (f.kind)
      KIND_SINGLE: begin
        r.value   = single_to_double(gather_bytes(f.raw_window, 4, be)[31:0]);
        r.is_real = 1'b1;
      end
      KIND_DOUBLE: begin
        r.value   = gather_bytes(f.raw_window, 8, be);
        r.is_real = 1'b1;
      end
      KIND_BOOL: r.value = (f.raw_window[7:0] != 0) ? 64'd1 : 64'd0;
      default: begin
        nbytes = (f.byte_count > 8) ? 8 : int'(f.byte_count);
        v = gather_bytes(f.raw_window, nbytes, be);
        if (f.bit_length > 0) begin
          mask = (f.bit_length >= 64) ? '1 : ((64'd1 << f.bit_length) - 64'd1);
          v = (v >> f.bit_start) & mask;
          if (f.kind == KIND_SINT) v = sign_fill(v, int'(f.bit_length));
        end else if (f.kind == KIND_SINT) begin
          v = sign_fill(v, nbytes * 8);
        end
        if (f.as_real) begin
          r.value   = int_to_double(v);
          r.is_real = 1'b1;
        end else begin
          r.value = v;
        end
      end
    endcase
    return r;
  endfunction

  // Sender: holds valid until the request is taken, gaps at random.
  task automatic send_field(rfd_in_t f);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decoded_q.push_back(decode_field(f, big_endian_q));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Register writes only while the pipeline is empty.
  task automatic set_byte_order(logic be);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= be;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    big_endian_q = be;
  endtask

  function automatic rfd_in_t make_field(logic [63:0] win, int bc, int bs, int bl,
                                         logic [2:0] k, logic ar, int off, int rlen);
    rfd_in_t f;
    f.raw_window    = win;
    f.byte_count    = 4'(bc);
    f.bit_start     = 6'(bs);
    f.bit_length    = 7'(bl);
    f.kind          = k;
    f.as_real       = ar;
    f.byte_offset   = 16'(off);
    f.record_length = 16'(rlen);
    return f;
  endfunction

  function automatic logic [63:0] rand_window();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = {32'd0, 1'b0, 8'hFF, 23'(w)};      // single inf / NaN
      3: w = {32'd0, 1'b1, 8'h00, 23'(w >> 5)}; // single subnormal
      default: ;
    endcase
    return w;
  endfunction

  // Mostly fitting fields; some overruns and out-of-range descriptors.
  function automatic rfd_in_t rand_field();
    rfd_in_t f;
    f.raw_window = rand_window();
    f.byte_count = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
    f.bit_start  = 6'($urandom());
    f.bit_length = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
    if ($urandom_range(3) == 0) f.bit_length = 0;
    f.kind       = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    f.as_real    = 1'($urandom());
    f.byte_offset = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(64));
    f.record_length = ($urandom_range(9) == 0) ? 16'($urandom())
                    : 16'(int'(f.byte_offset) + $urandom_range(12) - 2);
    return f;
  endfunction

  // Checker: compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result value=%h", $realtime, out_ch.data.value);
          errors++;
        end else begin
          automatic rfd_out_t exp_r = decoded_q.pop_front();
          if (exp_r.value !== out_ch.data.value) begin
            $display("%0t: value exp=%h got=%h", $realtime, exp_r.value, out_ch.data.value);
            errors++;
          end
          if (exp_r.is_real !== out_ch.data.is_real) begin
            $display("%0t: is_real exp=%b got=%b", $realtime, exp_r.is_real,
                     out_ch.data.is_real);
            errors++;
          end
          if (exp_r.fits !== out_ch.data.fits) begin
            $display("%0t: fits exp=%b got=%b", $realtime, exp_r.fits, out_ch.data.fits);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Directed: field extremes and every kind.
  task automatic test_directed();
    send_field(make_field('1, 8, 0, 0, KIND_UINT, 0, 0, 8));
    send_field(make_field(64'h80, 1, 0, 0, KIND_SINT, 0, 0, 1));
    send_field(make_field(64'h8000_0000_0000_0080, 8, 0, 0, KIND_SINT, 1, 0, 8));
    send_field(make_field(64'h1234_5678, 0, 0, 0, KIND_SINT, 0, 5, 5));   // zero bytes
    send_field(make_field('1, 15, 0, 0, KIND_UINT, 0, 0, 15));            // saturating count
    send_field(make_field('1, 15, 0, 0, KIND_UINT, 0, 0, 14));            // overrun
    send_field(make_field(64'hF0F0, 2, 4, 5, KIND_SINT, 0, 0, 2));
    send_field(make_field('1, 8, 63, 64, KIND_SINT, 1, 0, 8));            // bit length 64
    send_field(make_field('1, 8, 0, 127, KIND_SINT, 0, 0, 8));
    send_field(make_field(64'h00FF, 1, 0, 0, KIND_BOOL, 1, 0, 1));
    send_field(make_field(64'hFF00, 2, 0, 0, KIND_BOOL, 0, 0, 2));
    send_field(make_field(64'h0000_807F, 4, 0, 0, KIND_SINGLE, 0, 0, 4)); // inf when big-endian
    send_field(make_field(64'h0100_0000, 4, 0, 0, KIND_SINGLE, 0, 0, 4)); // subnormal when big-endian
    send_field(make_field(64'h0000_0080, 1, 0, 0, KIND_SINGLE, 0, 0, 3)); // overrun
    send_field(make_field(64'h0123_4567_89AB_CDEF, 1, 0, 0, KIND_DOUBLE, 0, 0, 8));
    send_field(make_field(64'hFFFF_FFFF_FFFF_FF7F, 8, 0, 0, KIND_UINT, 1, 0, 8)); // rounding
    send_field(make_field(64'h0300_0000_0000_0000, 8, 0, 0, KIND_UINT, 1, 0, 8));
    send_field(make_field('1, 3, 0, 0, 3'd7, 0, 16'hFFFF, 16'hFFFF));    // unused kind
    send_field(make_field('1, 8, 0, 0, KIND_UINT, 0, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_field(rand_field());
  endtask

  // Sender holds off until the pipeline is fully empty, then sends 20 random fields.
  task automatic test_drain_pause();
    wait_drained();
    test_random(20);
  endtask

  initial begin
    send_gap_pct = 13;
    sink_stall_pct = 88;
    big_endian_q = 1'b1;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_byte_order(1'b0);
    test_directed();
    test_random(120);

    send_gap_pct = 88;
    sink_stall_pct = 13;
    set_byte_order(1'b1);
    test_random(120);
    test_drain_pause();

    send_gap_pct = 0;
    sink_stall_pct = 0;
    set_byte_order(1'b0);
    test_random(100);

    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
